[src/line_offset_direction_estimator_unit_assert.svh]
// Assertion macros for the line offset and direction estimator.
`ifndef LINE_OFFSET_DIRECTION_ESTIMATOR_UNIT_ASSERT_SVH
`define LINE_OFFSET_DIRECTION_ESTIMATOR_UNIT_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent.
`define LODE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define LODE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/lode_pkg.sv]
package lode_pkg;

    localparam int ROWS_DEFAULT = 28;

    localparam int COL_W      = 5;
    localparam int ROW_IDX_W  = 6;
    localparam int FOUND_W    = 5;
    localparam int WH_W       = 7;
    localparam int ACC_W      = 38;
    localparam int MOP_W      = 8;
    localparam int DIVN_W     = 58;
    localparam int DIVD_W     = 36;
    localparam int OUT_W      = 16;
    localparam int ANG_W      = 23;
    localparam int K_W        = 30;
    localparam int PROD_W     = ANG_W + K_W;
    localparam int STEP_W     = 6;
    localparam int OFF_SHIFT  = 16;
    localparam int ANG_SHIFT  = 21;
    localparam int DIR_SHIFT  = 37;
    localparam int OFF_NUM_W  = 22;
    localparam int OFF_RCP_W  = 27;
    localparam int OFF_RCP_SH = 29;

    localparam logic [K_W-1:0]   K_TWO_OVER_PI = 30'd683565276;
    localparam logic [ANG_W-1:0] ANG_LIMIT     = 23'd5242880;
    localparam logic [OUT_W-1:0] OFF_LIMIT     = 16'd16384;
    localparam logic [OUT_W-1:0] DIR_LIMIT     = 16'd24576;

    typedef struct packed {
        logic             row_has_line;
        logic [COL_W-1:0] line_column;
        logic             last_row;
    } lode_row_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] offset_q14;
        logic signed [OUT_W-1:0] direction_q13;
        logic                    line_found;
        logic [FOUND_W-1:0]      found_row_index;
    } lode_result_t;

    typedef struct packed {
        logic                 seen;
        logic [ROW_IDX_W-1:0] first_row;
        logic [COL_W-1:0]     first_col;
    } lode_snap_t;

    typedef enum logic [3:0] {
        OP_LD,
        OP_MUL,
        OP_ST,
        OP_ADD,
        OP_SUB,
        OP_DIV,
        OP_BDIV,
        OP_STQ,
        OP_SCALE,
        OP_EMIT
    } lode_op_t;

    typedef enum logic [1:0] {
        SRC_W,
        SRC_H,
        SRC_DEN
    } lode_src_t;

    typedef enum logic [2:0] {
        MUL_W,
        MUL_H,
        MUL_15,
        MUL_5,
        MUL_3
    } lode_mul_t;

    typedef enum logic {
        DST_NUM,
        DST_DEN
    } lode_dst_t;

    typedef enum logic {
        DIV_OFF,
        DIV_ANG
    } lode_dsel_t;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } lode_seq_state_t;

    typedef struct packed {
        lode_op_t          op;
        lode_src_t         src;
        lode_mul_t         mul;
        lode_dst_t         dst;
        lode_dsel_t        dsel;
        logic [STEP_W-1:0] target;
    } lode_uop_t;

    typedef struct packed {
        logic div_busy;
        logic out_blocked;
    } lode_seq_stat_t;

    function automatic lode_uop_t mk(input lode_op_t op, input lode_src_t src,
                                     input lode_mul_t mul, input lode_dst_t dst,
                                     input lode_dsel_t dsel,
                                     input logic [STEP_W-1:0] target);
        lode_uop_t u;
        u.op     = op;
        u.src    = src;
        u.mul    = mul;
        u.dst    = dst;
        u.dsel   = dsel;
        u.target = target;
        return u;
    endfunction

    function automatic lode_uop_t ucode(input logic [STEP_W-1:0] step);
        lode_uop_t u;
        case (step)
            6'd0:    u = mk(OP_STQ,   SRC_W,   MUL_W,  DST_NUM, DIV_OFF, '0);
            6'd1:    u = mk(OP_LD,    SRC_H,   MUL_W,  DST_NUM, DIV_OFF, '0);
            6'd2:    u = mk(OP_MUL,   SRC_W,   MUL_H,  DST_NUM, DIV_OFF, '0);
            6'd3:    u = mk(OP_MUL,   SRC_W,   MUL_H,  DST_NUM, DIV_OFF, '0);
            6'd4:    u = mk(OP_MUL,   SRC_W,   MUL_H,  DST_NUM, DIV_OFF, '0);
            6'd5:    u = mk(OP_ST,    SRC_W,   MUL_W,  DST_DEN, DIV_OFF, '0);
            6'd6:    u = mk(OP_MUL,   SRC_W,   MUL_W,  DST_NUM, DIV_OFF, '0);
            6'd7:    u = mk(OP_MUL,   SRC_W,   MUL_15, DST_NUM, DIV_OFF, '0);
            6'd8:    u = mk(OP_ST,    SRC_W,   MUL_W,  DST_NUM, DIV_OFF, '0);
            6'd9:    u = mk(OP_LD,    SRC_DEN, MUL_W,  DST_NUM, DIV_OFF, '0);
            6'd10:   u = mk(OP_MUL,   SRC_W,   MUL_H,  DST_NUM, DIV_OFF, '0);
            6'd11:   u = mk(OP_MUL,   SRC_W,   MUL_15, DST_NUM, DIV_OFF, '0);
            6'd12:   u = mk(OP_ST,    SRC_W,   MUL_W,  DST_DEN, DIV_OFF, '0);
            6'd13:   u = mk(OP_LD,    SRC_W,   MUL_W,  DST_NUM, DIV_OFF, '0);
            6'd14:   u = mk(OP_MUL,   SRC_W,   MUL_W,  DST_NUM, DIV_OFF, '0);
            6'd15:   u = mk(OP_MUL,   SRC_W,   MUL_W,  DST_NUM, DIV_OFF, '0);
            6'd16:   u = mk(OP_MUL,   SRC_W,   MUL_H,  DST_NUM, DIV_OFF, '0);
            6'd17:   u = mk(OP_MUL,   SRC_W,   MUL_H,  DST_NUM, DIV_OFF, '0);
            6'd18:   u = mk(OP_MUL,   SRC_W,   MUL_5,  DST_NUM, DIV_OFF, '0);
            6'd19:   u = mk(OP_SUB,   SRC_W,   MUL_W,  DST_NUM, DIV_OFF, '0);
            6'd20:   u = mk(OP_LD,    SRC_W,   MUL_W,  DST_NUM, DIV_OFF, '0);
            6'd21:   u = mk(OP_MUL,   SRC_W,   MUL_W,  DST_NUM, DIV_OFF, '0);
            6'd22:   u = mk(OP_MUL,   SRC_W,   MUL_W,  DST_NUM, DIV_OFF, '0);
            6'd23:   u = mk(OP_MUL,   SRC_W,   MUL_W,  DST_NUM, DIV_OFF, '0);
            6'd24:   u = mk(OP_MUL,   SRC_W,   MUL_W,  DST_NUM, DIV_OFF, '0);
            6'd25:   u = mk(OP_MUL,   SRC_W,   MUL_3,  DST_NUM, DIV_OFF, '0);
            6'd26:   u = mk(OP_ADD,   SRC_W,   MUL_W,  DST_NUM, DIV_OFF, '0);
            6'd27:   u = mk(OP_DIV,   SRC_W,   MUL_W,  DST_NUM, DIV_ANG, '0);
            6'd28:   u = mk(OP_BDIV,  SRC_W,   MUL_W,  DST_NUM, DIV_ANG, 6'd28);
            6'd29:   u = mk(OP_STQ,   SRC_W,   MUL_W,  DST_NUM, DIV_ANG, '0);
            6'd30:   u = mk(OP_SCALE, SRC_W,   MUL_W,  DST_NUM, DIV_ANG, '0);
            6'd31:   u = mk(OP_EMIT,  SRC_W,   MUL_W,  DST_NUM, DIV_ANG, '0);
            default: u = mk(OP_EMIT,  SRC_W,   MUL_W,  DST_NUM, DIV_ANG, '0);
        endcase
        return u;
    endfunction

endpackage

[src/lode_row_tracker.sv]
module lode_row_tracker #(
    parameter int ROWS = lode_pkg::ROWS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  lode_pkg::lode_row_t  row,
    output lode_pkg::lode_snap_t snap
);

    localparam int CNT_W = $clog2(ROWS + 1);
    localparam int IDX_W = $clog2(ROWS);
    localparam int RIW   = lode_pkg::ROW_IDX_W;
    localparam int CW    = lode_pkg::COL_W;

    logic [CNT_W-1:0] cnt_reg, cnt_next, cnt_upd;
    logic             seen_reg, seen_next, seen_upd;
    logic [IDX_W-1:0] frow_reg, frow_next, frow_upd;
    logic [CW-1:0]    fcol_reg, fcol_next, fcol_upd;
    logic             in_range;
    logic             take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            seen_reg <= 1'b0;
            frow_reg <= '0;
            fcol_reg <= '0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            seen_reg <= seen_next;
            frow_reg <= frow_next;
            fcol_reg <= fcol_next;
        end
    end

    always_comb
    begin
        in_range = (cnt_reg < CNT_W'(ROWS));
        take     = in_range && row.row_has_line && !seen_reg;
        seen_upd = seen_reg | take;
        frow_upd = take ? cnt_reg[IDX_W-1:0] : frow_reg;
        fcol_upd = take ? row.line_column : fcol_reg;
        cnt_upd  = in_range ? cnt_reg + 1'b1 : cnt_reg;

        snap.seen      = seen_upd;
        snap.first_row = RIW'(frow_upd);
        snap.first_col = fcol_upd;

        cnt_next  = cnt_reg;
        seen_next = seen_reg;
        frow_next = frow_reg;
        fcol_next = fcol_reg;
        if (accept)
        begin
            if (row.last_row)
            begin
                cnt_next  = '0;
                seen_next = 1'b0;
                frow_next = '0;
                fcol_next = '0;
            end
            else
            begin
                cnt_next  = cnt_upd;
                seen_next = seen_upd;
                frow_next = frow_upd;
                fcol_next = fcol_upd;
            end
        end
    end

endmodule

[src/lode_sequencer.sv]
module lode_sequencer (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  lode_pkg::lode_seq_stat_t stat,
    output logic                     exec,
    output lode_pkg::lode_uop_t      uop
);

    lode_pkg::lode_seq_state_t     state_reg, state_next;
    logic [lode_pkg::STEP_W-1:0]   pc_reg, pc_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lode_pkg::SEQ_IDLE;
            pc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

    always_comb
    begin
        uop        = lode_pkg::ucode(pc_reg);
        exec       = (state_reg == lode_pkg::SEQ_RUN);
        state_next = state_reg;
        pc_next    = pc_reg;
        case (state_reg)
            lode_pkg::SEQ_IDLE:
            begin
                if (start)
                begin
                    state_next = lode_pkg::SEQ_RUN;
                    pc_next    = '0;
                end
            end
            lode_pkg::SEQ_RUN:
            begin
                case (uop.op)
                    lode_pkg::OP_BDIV:
                    begin
                        pc_next = stat.div_busy ? uop.target : pc_reg + 1'b1;
                    end
                    lode_pkg::OP_EMIT:
                    begin
                        if (!stat.out_blocked)
                        begin
                            state_next = lode_pkg::SEQ_IDLE;
                            pc_next    = '0;
                        end
                    end
                    default:
                    begin
                        pc_next = pc_reg + 1'b1;
                    end
                endcase
            end
            default:
            begin
                state_next = lode_pkg::SEQ_IDLE;
                pc_next    = '0;
            end
        endcase
    end

endmodule

[src/lode_divider.sv]
module lode_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [lode_pkg::DIVN_W-1:0] dividend,
    input  logic [lode_pkg::DIVD_W-1:0] divisor,
    output logic                        busy,
    output logic [lode_pkg::DIVN_W-1:0] quotient
);

    localparam int NW = lode_pkg::DIVN_W;
    localparam int DW = lode_pkg::DIVD_W;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] quo_reg, quo_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] dsr_reg, dsr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [DW:0]   shifted;
    logic [DW:0]   diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[NW-1]};
        diff      = shifted - {1'b0, dsr_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = diff[DW] ? shifted[DW-1:0] : diff[DW-1:0];
            quo_next = {quo_reg[NW-2:0], !diff[DW]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

[src/lode_datapath.sv]
module lode_datapath #(
    parameter int ROWS = lode_pkg::ROWS_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  lode_pkg::lode_snap_t   snap,
    input  logic                   exec,
    input  lode_pkg::lode_uop_t    uop,
    output logic                   div_busy,
    output lode_pkg::lode_result_t result
);

    localparam int HALF   = ROWS / 2;
    localparam int WH_W   = lode_pkg::WH_W;
    localparam int ACC_W  = lode_pkg::ACC_W;
    localparam int MOP_W  = lode_pkg::MOP_W;
    localparam int NW     = lode_pkg::DIVN_W;
    localparam int DW     = lode_pkg::DIVD_W;
    localparam int OUT_W  = lode_pkg::OUT_W;
    localparam int ANG_W  = lode_pkg::ANG_W;
    localparam int PROD_W = lode_pkg::PROD_W;
    localparam int DSH    = lode_pkg::DIR_SHIFT;
    localparam int FW     = lode_pkg::FOUND_W;
    localparam int ONW    = lode_pkg::OFF_NUM_W;
    localparam int OPW    = lode_pkg::OFF_NUM_W + lode_pkg::OFF_RCP_W;
    localparam int OQW    = OPW - lode_pkg::OFF_RCP_SH;
    localparam longint OFF_RCP = ((longint'(1) << lode_pkg::OFF_RCP_SH) + 2 * ROWS - 1)
                                 / (2 * ROWS);

    logic signed [WH_W-1:0]        w_reg, w_load;
    logic [WH_W-1:0]               h_reg, h_load;
    logic                          seen_reg;
    logic [FW-1:0]                 frow_reg;
    logic signed [ACC_W-1:0]       acc_reg, num_reg, den_reg;
    logic signed [OUT_W-1:0]       off_reg;
    logic [ANG_W-1:0]              ang_mag_reg;
    logic                          ang_neg_reg;
    logic [PROD_W-1:0]             prod_reg, prod_next;

    logic signed [ACC_W-1:0]       src_val, dst_val;
    logic signed [MOP_W-1:0]       mop;
    logic signed [ACC_W+MOP_W-1:0] mprod;
    logic [WH_W-1:0]               w_mag;
    logic [ACC_W-1:0]              num_mag;
    logic                          div_start;
    logic [NW-1:0]                 dividend;
    logic [DW-1:0]                 divisor;
    logic [NW-1:0]                 quotient;
    logic [ONW-1:0]                off_num;
    logic [OPW-1:0]                off_prod;
    logic [OQW-1:0]                off_quo;
    logic [OUT_W-1:0]              off_sat;
    logic [ANG_W-1:0]              ang_sat;
    logic [PROD_W-1:0]             rnd;
    logic [OUT_W-1:0]              dmag, dsat;

    lode_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .busy     (div_busy),
        .quotient (quotient)
    );

    always_comb
    begin
        w_load = snap.seen ? WH_W'(HALF) - WH_W'(snap.first_col) : WH_W'(HALF);
        h_load = snap.seen ? WH_W'(ROWS) - WH_W'(snap.first_row) : WH_W'(HALF);

        case (uop.src)
            lode_pkg::SRC_W:   src_val = ACC_W'(w_reg);
            lode_pkg::SRC_H:   src_val = ACC_W'(h_reg);
            lode_pkg::SRC_DEN: src_val = den_reg;
            default:           src_val = '0;
        endcase

        case (uop.mul)
            lode_pkg::MUL_W:  mop = MOP_W'(w_reg);
            lode_pkg::MUL_H:  mop = MOP_W'(h_reg);
            lode_pkg::MUL_15: mop = 8'sd15;
            lode_pkg::MUL_5:  mop = 8'sd5;
            lode_pkg::MUL_3:  mop = 8'sd3;
            default:          mop = '0;
        endcase
        mprod = acc_reg * mop;

        dst_val = (uop.dst == lode_pkg::DST_NUM) ? num_reg : den_reg;

        w_mag   = w_reg[WH_W-1] ? -w_reg : w_reg;
        num_mag = num_reg[ACC_W-1] ? -num_reg : num_reg;

        div_start = exec && (uop.op == lode_pkg::OP_DIV);
        dividend  = (NW'(num_mag) << lode_pkg::ANG_SHIFT) + NW'(den_reg);
        divisor   = {den_reg[DW-2:0], 1'b0};

        off_num  = (ONW'(w_mag) << lode_pkg::OFF_SHIFT) + ONW'(ROWS);
        off_prod = off_num * OPW'(OFF_RCP);
        off_quo  = off_prod[OPW-1:lode_pkg::OFF_RCP_SH];
        off_sat  = (off_quo > OQW'(lode_pkg::OFF_LIMIT)) ? lode_pkg::OFF_LIMIT
                                                         : off_quo[OUT_W-1:0];
        ang_sat = (quotient > NW'(lode_pkg::ANG_LIMIT)) ? lode_pkg::ANG_LIMIT
                                                        : quotient[ANG_W-1:0];

        prod_next = ang_mag_reg * lode_pkg::K_TWO_OVER_PI;

        rnd  = prod_reg + (PROD_W'(1) << (DSH - 1));
        dmag = OUT_W'(rnd[PROD_W-1:DSH]);
        dsat = (dmag > lode_pkg::DIR_LIMIT) ? lode_pkg::DIR_LIMIT : dmag;

        result.offset_q14      = off_reg;
        result.direction_q13   = ang_neg_reg ? -dsat : dsat;
        result.line_found      = seen_reg;
        result.found_row_index = seen_reg ? frow_reg : '0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            w_reg    <= w_load;
            h_reg    <= h_load;
            seen_reg <= snap.seen;
            frow_reg <= snap.first_row[FW-1:0];
        end
        if (exec)
        begin
            case (uop.op)
                lode_pkg::OP_LD:  acc_reg <= src_val;
                lode_pkg::OP_MUL: acc_reg <= mprod[ACC_W-1:0];
                lode_pkg::OP_ST,
                lode_pkg::OP_ADD,
                lode_pkg::OP_SUB:
                begin
                    if (uop.dst == lode_pkg::DST_NUM)
                    begin
                        num_reg <= (uop.op == lode_pkg::OP_ST)  ? acc_reg :
                                   (uop.op == lode_pkg::OP_ADD) ? dst_val + acc_reg :
                                                                  dst_val - acc_reg;
                    end
                    else
                    begin
                        den_reg <= (uop.op == lode_pkg::OP_ST)  ? acc_reg :
                                   (uop.op == lode_pkg::OP_ADD) ? dst_val + acc_reg :
                                                                  dst_val - acc_reg;
                    end
                end
                lode_pkg::OP_STQ:
                begin
                    if (uop.dsel == lode_pkg::DIV_OFF)
                    begin
                        off_reg <= w_reg[WH_W-1] ? -off_sat : off_sat;
                    end
                    else
                    begin
                        ang_mag_reg <= ang_sat;
                        ang_neg_reg <= num_reg[ACC_W-1];
                    end
                end
                lode_pkg::OP_SCALE: prod_reg <= prod_next;
                default:
                begin
                end
            endcase
        end
    end

endmodule

[src/line_offset_direction_estimator_unit.sv]
// channel  dir  handshake            payload
// row      in   row_valid/row_stall  lode_row_t: row_has_line, line_column, last_row
// res      out  res_valid/res_stall  lode_result_t: offset_q14, direction_q13,
//                                    line_found, found_row_index
//
// A row that is not the last one is taken while row_stall is low and updates the line search.
// The last row starts the microcode sequencer; row_stall holds while it runs the
// offset store and arithmetic steps, waits on the 58-step restoring divider, then
// stores the quotient, scales and emits.
// Reset is asynchronous and clears the search state, the sequencer and res_valid.
// The result waits in the output register; rows are taken meanwhile, and the
// sequencer holds on its final step if the previous result is still stalled.
`include "line_offset_direction_estimator_unit_assert.svh"

module line_offset_direction_estimator_unit #(
    parameter int ROWS = lode_pkg::ROWS_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   row_valid,
    output logic                   row_stall,
    input  lode_pkg::lode_row_t    row_item,
    output logic                   res_valid,
    input  logic                   res_stall,
    output lode_pkg::lode_result_t res_item
);

    lode_pkg::lode_snap_t     snap;
    lode_pkg::lode_seq_stat_t stat;
    lode_pkg::lode_uop_t      uop;
    lode_pkg::lode_result_t   result;
    lode_pkg::lode_result_t   res_item_reg;
    logic                     res_valid_reg, res_valid_next;
    logic                     exec;
    logic                     div_busy;
    logic                     row_accept;
    logic                     start;
    logic                     emit;

    lode_row_tracker #(
        .ROWS (ROWS)
    ) u_tracker (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (row_accept),
        .row    (row_item),
        .snap   (snap)
    );

    lode_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .exec  (exec),
        .uop   (uop)
    );

    lode_datapath #(
        .ROWS (ROWS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (start),
        .snap     (snap),
        .exec     (exec),
        .uop      (uop),
        .div_busy (div_busy),
        .result   (result)
    );

    always_comb
    begin
        row_stall        = exec;
        row_accept       = row_valid && !row_stall;
        start            = row_accept && row_item.last_row;
        stat.div_busy    = div_busy;
        stat.out_blocked = res_valid_reg && res_stall;
        emit             = exec && (uop.op == lode_pkg::OP_EMIT) && !stat.out_blocked;
        if (emit)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_item_reg <= result;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    `LODE_ASSERT_IMPL(a_emit_after_divide, emit, !div_busy, "result formed while divider busy")
    `LODE_ASSERT_IMPL(a_no_row_while_divide, div_busy, !row_accept, "row taken while divider busy")
    `LODE_ASSERT_NEXT(a_last_row_starts, start, row_stall, "last row did not start sequencer")
    `LODE_ASSERT_IMPL(a_result_from_run, $rose(res_valid), $past(exec), "result without sequencer run")

endmodule
